### src/nearest_pair_linear_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// nearest pair linear interpolator assertion macros
// shared property forms for the checker of the interpolator core
// ----------------------------------------------------------------------------
`ifndef NEAREST_PAIR_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define NEAREST_PAIR_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define NPLI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npli check failed");

// next-cycle implication, held off during reset
`define NPLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npli check failed");

`endif

### src/npli_pkg.sv
// ----------------------------------------------------------------------------
// npli_pkg
// types and constants of the nearest pair linear interpolator
// ----------------------------------------------------------------------------
package npli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int ENTRIES_W   = 7;
  localparam int DIST_W      = DATA_W + 1;
  localparam int PROD_W      = 2 * DIST_W;
  localparam int QUOT_BITS   = 42;
  localparam int QCNT_W      = 6;
  localparam int MAG_W       = 41;
  localparam int SUM_W       = MAG_W + 2;
  localparam int ADDR_W      = 3;
  localparam int PDATA_W     = 32;

  localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic REG_ENTRIES_USED = 1'b0;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_WRITE = 2'd1;
  localparam logic [1:0] STATUS_FEW   = 2'd2;
  localparam logic [1:0] STATUS_EQUAL = 2'd3;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] query_value;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic                     saturated;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ORDER,
    ST_MUL,
    ST_DPREP,
    ST_DIV,
    ST_RESULT,
    ST_FINISH
  } state_t;

endpackage

### src/nearest_pair_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// nearest_pair_linear_interpolator_core
// breakpoint table with nearest pair search and linear interpolation
// ----------------------------------------------------------------------------
// One item is in work at a time. A write item stores one (x, y) breakpoint in
// the table memory and goes straight to the finish state, as does a query with
// fewer than two entries in use. Any other query passes through the scan,
// order, multiply, divider set-up, divide, result and finish states: the
// search reads the table memory one entry per cycle through its single read
// port, and the quotient comes from a restoring divider that yields one bit
// per cycle of its 42-bit quotient. When the chosen pair has equal x or the
// quotient is known to exceed the cap, the divider is skipped. A stalled
// result holds the finished item back until the result register frees up.
// The result register lets the next item enter while a result waits.
module nearest_pair_linear_interpolator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  npli_pkg::req_item_t               req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output npli_pkg::rsp_item_t               rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npli_pkg::ADDR_W-1:0]       paddr,
  input  logic [npli_pkg::PDATA_W-1:0]      pwdata,
  output logic [npli_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  npli_pkg::state_t state, state_next;

  logic [npli_pkg::ENTRIES_W-1:0] entries_used;

  logic [2*npli_pkg::DATA_W-1:0] table_mem [npli_pkg::TABLE_DEPTH];
  logic [2*npli_pkg::DATA_W-1:0] rd_data;

  logic signed [npli_pkg::DATA_W-1:0] q;
  logic [npli_pkg::CNT_W-1:0]         n_used;
  logic [npli_pkg::CNT_W-1:0]         cnt;
  logic                               s1_valid;
  logic                               s2_valid;
  logic [npli_pkg::DIST_W-1:0]        s2_dist;
  logic signed [npli_pkg::DATA_W-1:0] s2_x, s2_y;
  logic                               have1, have2;
  logic [npli_pkg::DIST_W-1:0]        d1, d2;
  logic signed [npli_pkg::DATA_W-1:0] x1, y1, x2, y2;

  logic signed [npli_pkg::DATA_W-1:0] ylo;
  logic [npli_pkg::DIST_W-1:0]        dx;
  logic signed [npli_pkg::DIST_W-1:0] dy, dq;
  logic [npli_pkg::PROD_W-1:0]        prod;
  logic                               neg;
  logic                               big;
  logic [npli_pkg::DIST_W-1:0]        rem;
  logic [npli_pkg::QUOT_BITS-1:0]     dvd;
  logic [npli_pkg::QUOT_BITS-1:0]     quot;
  logic [npli_pkg::QCNT_W-1:0]        div_cnt;

  npli_pkg::rsp_item_t pend;

  logic                               accept;
  logic                               done_last;
  logic                               quit_scan;
  logic [npli_pkg::CNT_W-1:0]         n_clip;
  logic signed [npli_pkg::DATA_W-1:0] rd_x, rd_y;
  logic signed [npli_pkg::DIST_W-1:0] diff;
  logic [npli_pkg::DIST_W-1:0]        diff_mag;
  logic                               swap;
  logic signed [npli_pkg::DATA_W-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
  logic [npli_pkg::DIST_W-1:0]        dy_mag, dq_mag;
  logic [npli_pkg::DIST_W-1:0]        prod_hi;
  logic [npli_pkg::DIST_W:0]          rem_sh;
  logic                               qbit;
  logic [npli_pkg::MAG_W-1:0]         mag;
  logic signed [npli_pkg::SUM_W-1:0]  ylo_ext, mag_ext, sum;
  logic                               sat_hi, sat_lo;
  logic                               rsp_load;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == npli_pkg::REG_ENTRIES_USED) ?
                  npli_pkg::PDATA_W'(entries_used) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == npli_pkg::REG_ENTRIES_USED) begin
      entries_used <= pwdata[npli_pkg::ENTRIES_W-1:0];
    end
  end

  // datapath helpers
  assign accept   = req_valid && !req_stall;
  assign n_clip   = (entries_used > npli_pkg::ENTRIES_W'(npli_pkg::TABLE_DEPTH)) ?
                    npli_pkg::CNT_W'(npli_pkg::TABLE_DEPTH) :
                    npli_pkg::CNT_W'(entries_used);
  assign rd_x     = rd_data[2*npli_pkg::DATA_W-1:npli_pkg::DATA_W];
  assign rd_y     = rd_data[npli_pkg::DATA_W-1:0];
  assign diff     = {q[npli_pkg::DATA_W-1], q} - {rd_x[npli_pkg::DATA_W-1], rd_x};
  assign diff_mag = diff[npli_pkg::DIST_W-1] ? (~diff + 1'b1) : diff;
  assign quit_scan = (cnt == n_used) && !s1_valid && !s2_valid;

  assign swap  = x1 > x2;
  assign xlo_c = swap ? x2 : x1;
  assign ylo_c = swap ? y2 : y1;
  assign xhi_c = swap ? x1 : x2;
  assign yhi_c = swap ? y1 : y2;

  assign dy_mag  = dy[npli_pkg::DIST_W-1] ? (~dy + 1'b1) : dy;
  assign dq_mag  = dq[npli_pkg::DIST_W-1] ? (~dq + 1'b1) : dq;
  assign prod_hi = npli_pkg::DIST_W'(prod[npli_pkg::PROD_W-1:npli_pkg::QUOT_BITS]);

  assign rem_sh    = {rem, dvd[npli_pkg::QUOT_BITS-1]};
  assign qbit      = rem_sh >= {1'b0, dx};
  assign done_last = div_cnt == npli_pkg::QCNT_W'(npli_pkg::QUOT_BITS - 1);

  assign mag     = (big || quot > npli_pkg::QUOT_BITS'(npli_pkg::MAG_CAP)) ?
                   npli_pkg::MAG_CAP : quot[npli_pkg::MAG_W-1:0];
  assign ylo_ext = npli_pkg::SUM_W'(ylo);
  assign mag_ext = $signed({2'b00, mag});
  assign sum     = neg ? (ylo_ext - mag_ext) : (ylo_ext + mag_ext);
  assign sat_hi  = sum > $signed(npli_pkg::SUM_W'({1'b0, {(npli_pkg::DATA_W-1){1'b1}}}));
  assign sat_lo  = sum < -$signed(npli_pkg::SUM_W'({1'b1, {(npli_pkg::DATA_W-1){1'b0}}}));

  assign rsp_load = (state == npli_pkg::ST_FINISH) && (!rsp_valid || !rsp_stall);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    case (state)
      npli_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req.req_type == npli_pkg::REQ_WRITE || n_clip < npli_pkg::CNT_W'(2)) begin
            state_next = npli_pkg::ST_FINISH;
          end else begin
            state_next = npli_pkg::ST_SCAN;
          end
        end
      end
      npli_pkg::ST_SCAN: begin
        if (quit_scan) begin
          state_next = npli_pkg::ST_ORDER;
        end
      end
      npli_pkg::ST_ORDER: begin
        if (xlo_c == xhi_c) begin
          state_next = npli_pkg::ST_FINISH;
        end else begin
          state_next = npli_pkg::ST_MUL;
        end
      end
      npli_pkg::ST_MUL: begin
        state_next = npli_pkg::ST_DPREP;
      end
      npli_pkg::ST_DPREP: begin
        if (prod_hi >= dx) begin
          state_next = npli_pkg::ST_RESULT;
        end else begin
          state_next = npli_pkg::ST_DIV;
        end
      end
      npli_pkg::ST_DIV: begin
        if (done_last) begin
          state_next = npli_pkg::ST_RESULT;
        end
      end
      npli_pkg::ST_RESULT: begin
        state_next = npli_pkg::ST_FINISH;
      end
      npli_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = npli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = npli_pkg::ST_IDLE;
      end
    endcase
  end

  // breakpoint memory
  always_ff @(posedge clk) begin
    if (accept && req.req_type == npli_pkg::REQ_WRITE) begin
      table_mem[req.entry_index] <= {req.entry_x, req.entry_y};
    end
    if (state == npli_pkg::ST_SCAN && cnt < n_used) begin
      rd_data <= table_mem[cnt[npli_pkg::IDX_W-1:0]];
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      have1    <= 1'b0;
      have2    <= 1'b0;
    end else if (state == npli_pkg::ST_IDLE) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      have1    <= 1'b0;
      have2    <= 1'b0;
    end else if (state == npli_pkg::ST_SCAN) begin
      s1_valid <= cnt < n_used;
      if (cnt < n_used) begin
        cnt <= cnt + 1'b1;
      end
      s2_valid <= s1_valid;
      if (s2_valid) begin
        if (!have1 || s2_dist < d1) begin
          have1 <= 1'b1;
          have2 <= have1;
        end else begin
          have2 <= 1'b1;
        end
      end
    end
  end

  // scan payload: best two distances, earliest index wins a tie
  always_ff @(posedge clk) begin
    if (accept) begin
      q      <= req.query_value;
      n_used <= n_clip;
    end
    if (s1_valid) begin
      s2_dist <= diff_mag;
      s2_x    <= rd_x;
      s2_y    <= rd_y;
    end
    if (state == npli_pkg::ST_SCAN && s2_valid) begin
      if (!have1 || s2_dist < d1) begin
        d2 <= d1;
        x2 <= x1;
        y2 <= y1;
        d1 <= s2_dist;
        x1 <= s2_x;
        y1 <= s2_y;
      end else if (!have2 || s2_dist < d2) begin
        d2 <= s2_dist;
        x2 <= s2_x;
        y2 <= s2_y;
      end
    end
  end

  // interpolation datapath
  always_ff @(posedge clk) begin
    case (state)
      npli_pkg::ST_IDLE: begin
        if (req_valid) begin
          pend.result_value <= '0;
          pend.saturated    <= 1'b0;
          pend.status       <= (req.req_type == npli_pkg::REQ_WRITE) ?
                               npli_pkg::STATUS_WRITE : npli_pkg::STATUS_FEW;
        end
      end
      npli_pkg::ST_ORDER: begin
        pend.result_value <= '0;
        pend.saturated    <= 1'b0;
        pend.status       <= npli_pkg::STATUS_EQUAL;
        ylo <= ylo_c;
        dx  <= npli_pkg::DIST_W'({xhi_c[npli_pkg::DATA_W-1], xhi_c} -
                                 {xlo_c[npli_pkg::DATA_W-1], xlo_c});
        dy  <= {yhi_c[npli_pkg::DATA_W-1], yhi_c} - {ylo_c[npli_pkg::DATA_W-1], ylo_c};
        dq  <= {q[npli_pkg::DATA_W-1], q} - {xlo_c[npli_pkg::DATA_W-1], xlo_c};
      end
      npli_pkg::ST_MUL: begin
        prod <= dy_mag * dq_mag;
        neg  <= dy[npli_pkg::DIST_W-1] != dq[npli_pkg::DIST_W-1];
      end
      npli_pkg::ST_DPREP: begin
        big     <= prod_hi >= dx;
        rem     <= prod_hi;
        dvd     <= prod[npli_pkg::QUOT_BITS-1:0];
        quot    <= '0;
        div_cnt <= '0;
      end
      npli_pkg::ST_DIV: begin
        rem     <= qbit ? npli_pkg::DIST_W'(rem_sh - {1'b0, dx}) :
                          rem_sh[npli_pkg::DIST_W-1:0];
        dvd     <= {dvd[npli_pkg::QUOT_BITS-2:0], 1'b0};
        quot    <= {quot[npli_pkg::QUOT_BITS-2:0], qbit};
        div_cnt <= div_cnt + 1'b1;
      end
      npli_pkg::ST_RESULT: begin
        pend.status    <= npli_pkg::STATUS_OK;
        pend.saturated <= sat_hi || sat_lo;
        if (sat_hi) begin
          pend.result_value <= {1'b0, {(npli_pkg::DATA_W-1){1'b1}}};
        end else if (sat_lo) begin
          pend.result_value <= {1'b1, {(npli_pkg::DATA_W-1){1'b0}}};
        end else begin
          pend.result_value <= sum[npli_pkg::DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= pend;
    end
  end

endmodule

### src/npli_checker.sv
// ----------------------------------------------------------------------------
// npli_checker
// port-level checks of the nearest pair linear interpolator core
// ----------------------------------------------------------------------------
`include "nearest_pair_linear_interpolator_core_defines.svh"

module npli_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input npli_pkg::req_item_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input npli_pkg::rsp_item_t rsp
);

  // a stalled result holds
  `NPLI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // one item in work at a time
  `NPLI_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)

  // writes and errors carry a zero result
  `NPLI_ASSERT_NOW(a_zero_on_non_ok, clk, rst,
                   rsp_valid && rsp.status != npli_pkg::STATUS_OK,
                   rsp.result_value == '0 && !rsp.saturated)

  // clipping lands on a range limit
  `NPLI_ASSERT_NOW(a_sat_at_limit, clk, rst, rsp_valid && rsp.saturated,
                   rsp.result_value == 32'h7fff_ffff || rsp.result_value == 32'h8000_0000)

endmodule

bind nearest_pair_linear_interpolator_core npli_checker u_npli_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### dv/nearest_pair_linear_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_pair_linear_interpolator_core_tb
// Drives write and lookup items into the interpolator core and checks every
// result against a predictor that keeps its own copy of the breakpoint table.
// The table size register is changed between phases over the APB port. The
// stimulus starts with corner cases: short table, extreme coordinates,
// clipping, equal breakpoints, distance ties and truncation. Random phases
// follow, most with idle cycles on both sides, and one long output hold-off.
// ----------------------------------------------------------------------------

class lookup_board;
  longint     tab_x[npli_pkg::TABLE_DEPTH];
  longint     tab_y[npli_pkg::TABLE_DEPTH];
  bit         filled[npli_pkg::TABLE_DEPTH];
  int unsigned entries;
  npli_pkg::rsp_item_t pending[$];
  int         errors;
  int         writes;
  int         lookups;
  int         hits_ok;
  int         hits_sat;
  int         hits_few;
  int         hits_equal;

  function void set_entries(logic [npli_pkg::ENTRIES_W-1:0] val);
    entries = val;
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  function longint gap(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function npli_pkg::rsp_item_t interpolate_at(logic signed [npli_pkg::DATA_W-1:0] qv);
    npli_pkg::rsp_item_t r;
    int           n, i, m1, m2, a, b;
    longint       q, d, d1, d2, res, mag;
    logic [127:0] ady, adq, span, quo;
    bit           found, neg;
    r = '0;
    n = (entries > npli_pkg::TABLE_DEPTH) ? npli_pkg::TABLE_DEPTH : int'(entries);
    if (n < 2) begin
      r.status = npli_pkg::STATUS_FEW;
      return r;
    end
    q = qv;
    m1 = 0;
    d1 = gap(q, tab_x[0]);
    for (i = 1; i < n; i++) begin
      d = gap(q, tab_x[i]);
      if (d < d1) begin
        d1 = d;
        m1 = i;
      end
    end
    found = 1'b0;
    m2 = 0;
    d2 = 0;
    for (i = 0; i < n; i++) begin
      if (i != m1) begin
        d = gap(q, tab_x[i]);
        if (!found || d < d2) begin
          d2 = d;
          m2 = i;
          found = 1'b1;
        end
      end
    end
    if (tab_x[m1] > tab_x[m2]) begin
      a = m2;
      b = m1;
    end else begin
      a = m1;
      b = m2;
    end
    if (tab_x[a] == tab_x[b]) begin
      r.status = npli_pkg::STATUS_EQUAL;
      return r;
    end
    neg = ((tab_y[b] - tab_y[a]) < 0) != ((q - tab_x[a]) < 0);
    ady = gap(tab_y[b], tab_y[a]);
    adq = gap(q, tab_x[a]);
    span = tab_x[b] - tab_x[a];
    quo = (ady * adq) / span;
    if (quo > 128'(npli_pkg::MAG_CAP)) mag = longint'(npli_pkg::MAG_CAP);
    else mag = quo[63:0];
    res = neg ? tab_y[a] - mag : tab_y[a] + mag;
    r.status = npli_pkg::STATUS_OK;
    if (res > 64'sh7fff_ffff) begin
      r.result_value = 32'h7fff_ffff;
      r.saturated = 1'b1;
    end else if (res < -64'sh8000_0000) begin
      r.result_value = 32'h8000_0000;
      r.saturated = 1'b1;
    end else begin
      r.result_value = res[31:0];
    end
    return r;
  endfunction

  function void note_request(npli_pkg::req_item_t it);
    npli_pkg::rsp_item_t r;
    if (it.req_type == npli_pkg::REQ_WRITE) begin
      tab_x[it.entry_index] = $signed(it.entry_x);
      tab_y[it.entry_index] = $signed(it.entry_y);
      filled[it.entry_index] = 1'b1;
      r = '0;
      r.status = npli_pkg::STATUS_WRITE;
      writes++;
    end else begin
      r = interpolate_at(it.query_value);
      lookups++;
      case (r.status)
        npli_pkg::STATUS_OK: begin
          hits_ok++;
          if (r.saturated) hits_sat++;
        end
        npli_pkg::STATUS_FEW: hits_few++;
        default: hits_equal++;
      endcase
    end
    pending = {pending, r};
  endfunction

  function void check_result(npli_pkg::rsp_item_t got);
    npli_pkg::rsp_item_t want;
    if (pending.size() == 0) begin
      $error("result with no item outstanding: result_value %0d status %0d",
             $signed(got.result_value), got.status);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.result_value !== want.result_value) begin
      $error("result_value expected %0d got %0d",
             $signed(want.result_value), $signed(got.result_value));
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated expected %0d got %0d", want.saturated, got.saturated);
      errors++;
    end
  endfunction

  function void close_out();
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      errors++;
    end
  endfunction
endclass

module nearest_pair_linear_interpolator_core_tb;

  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 115;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 150;
  localparam int QUIET_LIMIT    = 5000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              req_valid = 1'b0;
  logic                              req_stall;
  npli_pkg::req_item_t               req = '0;
  logic                              rsp_valid;
  logic                              rsp_stall = 1'b0;
  npli_pkg::rsp_item_t               rsp;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [npli_pkg::ADDR_W-1:0]       paddr = '0;
  logic [npli_pkg::PDATA_W-1:0]      pwdata = '0;
  logic [npli_pkg::PDATA_W-1:0]      prdata;
  logic                              pready;

  lookup_board          board;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  logic                 hold_on = 1'b0;
  int                   hold_count = 0;
  int                   table_sizes = 0;
  int                   plan[NUM_PHASES] = '{2, 64, 5, 127, 3, 33, 65, 16, 1, 64, 0, 9};

  nearest_pair_linear_interpolator_core dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_on && hold_count < HOLD_CYCLES) begin
      rsp_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input npli_pkg::req_item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    board.note_request(it);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [npli_pkg::ENTRIES_W-1:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= npli_pkg::ADDR_W'(4 * npli_pkg::REG_ENTRIES_USED);
    pwdata <= ($urandom() & 32'hffff_ff80) | npli_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_entries(val);
    table_sizes++;
  endtask

  task automatic put_entry(input int idx, input logic [npli_pkg::DATA_W-1:0] x,
                           input logic [npli_pkg::DATA_W-1:0] y);
    npli_pkg::req_item_t it;
    it.req_type = npli_pkg::REQ_WRITE;
    it.entry_index = npli_pkg::IDX_W'(idx);
    it.entry_x = x;
    it.entry_y = y;
    it.query_value = $urandom();
    send_item(it);
  endtask

  task automatic ask(input logic [npli_pkg::DATA_W-1:0] q);
    npli_pkg::req_item_t it;
    it.req_type = npli_pkg::REQ_QUERY;
    it.entry_index = npli_pkg::IDX_W'($urandom());
    it.entry_x = $urandom();
    it.entry_y = $urandom();
    it.query_value = q;
    send_item(it);
  endtask

  function automatic logic signed [npli_pkg::DATA_W-1:0] pick_coord(int eff);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return (int'($urandom_range(0, 4000)) - 2000) * 1024;
    if (sel < 75) return $urandom();
    if (sel < 85 && eff > 0) return board.tab_x[$urandom_range(eff - 1)][31:0];
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return 32'h1;
    endcase
  endfunction

  function automatic npli_pkg::req_item_t random_item(int eff);
    npli_pkg::req_item_t it;
    int          i, hole, s;
    int unsigned sel;
    hole = -1;
    for (i = eff - 1; i >= 0; i--) begin
      if (!board.filled[i]) hole = i;
    end
    it.req_type = ($urandom_range(99) < 30) ? npli_pkg::REQ_WRITE : npli_pkg::REQ_QUERY;
    it.entry_index = (eff > 0 && $urandom_range(99) < 80) ?
                     npli_pkg::IDX_W'($urandom_range(eff - 1)) :
                     npli_pkg::IDX_W'($urandom());
    it.entry_x = pick_coord(eff);
    it.entry_y = pick_coord(0);
    sel = $urandom_range(99);
    s = (eff > 0) ? int'($urandom_range(eff - 1)) : 0;
    if (sel < 40 && eff > 0)
      it.query_value = 32'(board.tab_x[s] + (int'($urandom_range(0, 6000)) - 3000) * 16);
    else if (sel < 55 && eff > 0)
      it.query_value = board.tab_x[s][31:0];
    else if (sel < 85)
      it.query_value = $urandom();
    else
      it.query_value = pick_coord(0);
    if (hole >= 0) begin
      it.req_type = npli_pkg::REQ_WRITE;
      it.entry_index = npli_pkg::IDX_W'(hole);
    end
    return it;
  endfunction

  initial begin : stimulus
    int p, k, eff;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct <= 29;
    recv_idle_pct <= 53;

    ask(32'h8000_0000);
    put_entry(0, 32'h8000_0000, 32'h7fff_ffff);
    put_entry(1, 32'h7fff_ffff, 32'h8000_0000);
    put_entry(63, 32'h0, 32'h0);
    set_table_size(1);
    ask(32'h7fff_ffff);
    set_table_size(2);
    ask(32'h0);
    ask(32'h8000_0000);
    ask(32'h7fff_ffff);
    put_entry(0, 32'h0, 32'h0);
    put_entry(1, 32'h1, 32'h7fff_ffff);
    ask(32'h7fff_ffff);
    ask(-32'sd2);
    put_entry(1, 32'h1, 32'h8000_0000);
    ask(32'h7fff_ffff);
    put_entry(0, 32'd5, 32'd7);
    put_entry(1, 32'd5, 32'd9);
    ask(32'd5);
    put_entry(0, 32'h0, 32'h0);
    put_entry(1, 32'd3, -32'sd1);
    ask(32'd2);
    ask(32'd4);
    put_entry(2, 32'd8, 32'd80);
    put_entry(3, -32'sd4, -32'sd40);
    set_table_size(4);
    put_entry(1, 32'd4, 32'd40);
    ask(32'd2);
    ask(32'd6);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct <= 53;
        recv_idle_pct <= 29;
      end
      if (p == 8) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      set_table_size(npli_pkg::ENTRIES_W'(plan[p]));
      if (p == PRESSURE_PHASE) hold_on <= 1'b1;
      eff = (plan[p] > npli_pkg::TABLE_DEPTH) ? npli_pkg::TABLE_DEPTH : plan[p];
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item(eff));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    board.close_out();
    $display("covered %0d table writes and %0d lookups over %0d table sizes",
             board.writes, board.lookups, table_sizes);
    $display("lookups: %0d interpolated (%0d clipped), %0d short table, %0d equal x",
             board.hits_ok, board.hits_sat, board.hits_few, board.hits_equal);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
